// File: design/atrp_pkg.sv
// Shared widths, constants, item types and the arctangent table of the tilt unit.
package atrp_pkg;

  localparam int DATA_W     = 16;
  localparam int SQR_W      = 31;
  localparam int SQ_W       = 32;
  localparam int NUM_W      = 17;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 34;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CV_W       = 36;
  localparam int Z_W        = 32;
  localparam int MAG_W      = 31;
  localparam int RAD_W      = 16;
  localparam int DEG_W      = 8;
  localparam int DMAG_W     = 7;
  localparam int K_W        = 30;
  localparam int PROD_W     = MAG_W + K_W;
  localparam int RSUM_W     = 48;
  localparam int IDX_W      = 5;
  localparam int ATAN_LEN   = 24;
  localparam int FIFO_DEPTH = 4;

  localparam int ANGLE_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS_DEF    = 16;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 32'sd1686629713;
  localparam logic [K_W-1:0]        RAD2DEG_Q24 = 30'd961263668;
  localparam int                    DEG_SHIFT   = 54;
  localparam logic [DMAG_W-1:0]     DEG_MAX     = 7'd90;

  typedef struct packed {
    logic [SQ_W-1:0]         sq;
    logic signed [NUM_W-1:0] num;
  } atrp_lane_t;

  typedef struct packed {
    atrp_lane_t roll;
    atrp_lane_t pitch;
    logic       zero;
  } atrp_item_t;

  typedef struct packed {
    logic [SQ_W-1:0]         rad;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
    logic signed [NUM_W-1:0] num;
  } atrp_sq_st_t;

  typedef struct packed {
    logic [ROOT_W-1:0]       r;
    logic signed [NUM_W-1:0] num;
  } atrp_hyp_t;

  typedef struct packed {
    atrp_hyp_t roll;
    atrp_hyp_t pitch;
    logic      zero;
  } atrp_hyp_item_t;

  typedef struct packed {
    logic signed [CV_W-1:0] x;
    logic signed [CV_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } atrp_cv_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sd843314856;
      5'd1:    v = 32'sd497837829;
      5'd2:    v = 32'sd263043836;
      5'd3:    v = 32'sd133525158;
      5'd4:    v = 32'sd67021686;
      5'd5:    v = 32'sd33543515;
      5'd6:    v = 32'sd16775850;
      5'd7:    v = 32'sd8388437;
      5'd8:    v = 32'sd4194282;
      5'd9:    v = 32'sd2097149;
      5'd10:   v = 32'sd1048575;
      5'd11:   v = 32'sd524287;
      5'd12:   v = 32'sd262143;
      5'd13:   v = 32'sd131071;
      5'd14:   v = 32'sd65535;
      5'd15:   v = 32'sd32767;
      5'd16:   v = 32'sd16383;
      5'd17:   v = 32'sd8191;
      5'd18:   v = 32'sd4095;
      5'd19:   v = 32'sd2047;
      5'd20:   v = 32'sd1023;
      5'd21:   v = 32'sd511;
      5'd22:   v = 32'sd255;
      5'd23:   v = 32'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/accel_tilt_roll_pitch_unit.sv
// Top level of the accelerometer tilt unit: roll and pitch from one sample.
//
// Usage: present a signed 16-bit X, Y, Z sample on in_accel_* with in_valid;
// the item is taken at a rising edge where in_valid and in_ready are high.
// Each item yields exactly one result on out_* (roll and pitch in radians
// with ANGLE_FRAC_BITS fraction bits, and in whole degrees truncated toward
// zero), taken at an edge where out_valid and out_ready are high.
// Throughput: one item per cycle, sustained while out_ready stays high, with no
// gaps between items. Path: the accepting edge loads the first of two front
// stages (squares, sums); then come one queue slot, 32 square-root stages (one
// root bit each), one stage per CORDIC rotation, and three formatting stages
// ending in the output register.
// A stalled receiver freezes the back-end pipeline in place; the four-entry
// queue keeps absorbing items from the front end until it fills, and only
// then does in_ready drop.
// Reset (rst_n low at a clock edge) empties the queue and clears every stage
// valid; no results are in flight afterwards and nothing needs priming.
module accel_tilt_roll_pitch_unit #(
  parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = atrp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [atrp_pkg::DATA_W-1:0]  in_accel_x,
  input  logic signed [atrp_pkg::DATA_W-1:0]  in_accel_y,
  input  logic signed [atrp_pkg::DATA_W-1:0]  in_accel_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [atrp_pkg::RAD_W-1:0]   out_roll_rad,
  output logic signed [atrp_pkg::RAD_W-1:0]   out_pitch_rad,
  output logic signed [atrp_pkg::DEG_W-1:0]   out_roll_deg,
  output logic signed [atrp_pkg::DEG_W-1:0]   out_pitch_deg
);

  atrp_pkg::atrp_item_t     fr_item, q_item;
  atrp_pkg::atrp_hyp_item_t hyp_item;
  logic fr_vld, fr_rdy, q_vld, hyp_vld, cz_vld, cz_zero;
  logic signed [atrp_pkg::Z_W-1:0] z_roll, z_pitch;
  logic adv;

  // Advance the whole back end whenever the output register is free or emptying.
  assign adv = !out_valid || out_ready;

  atrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .item_vld   (fr_vld),
    .item_rdy   (fr_rdy),
    .item       (fr_item)
  );

  // Decouple the front end from stalls in the back end.
  atrp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (fr_vld),
    .push_rdy  (fr_rdy),
    .push_item (fr_item),
    .pop_vld   (q_vld),
    .pop       (adv),
    .pop_item  (q_item)
  );

  // Hypotenuse in Q16 for both lanes.
  atrp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (q_vld),
    .in_item  (q_item),
    .out_vld  (hyp_vld),
    .out_item (hyp_item)
  );

  // Angle of (hypotenuse, numerator) in Q30.
  atrp_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_vld      (hyp_vld),
    .in_item     (hyp_item),
    .out_vld     (cz_vld),
    .out_z_roll  (z_roll),
    .out_z_pitch (z_pitch),
    .out_zero    (cz_zero)
  );

  // Clamp, scale and hold the result for the receiver.
  atrp_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (cz_vld),
    .in_z_roll  (z_roll),
    .in_z_pitch (z_pitch),
    .in_zero    (cz_zero),
    .out_vld    (out_valid),
    .roll_rad   (out_roll_rad),
    .pitch_rad  (out_pitch_rad),
    .roll_deg   (out_roll_deg),
    .pitch_deg  (out_pitch_deg)
  );

  a_roll_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_roll_deg <= 8'sd90) && (out_roll_deg >= -8'sd90)))
    else $error("roll degrees out of range");

  a_pitch_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pitch_deg <= 8'sd90) && (out_pitch_deg >= -8'sd90)))
    else $error("pitch degrees out of range");

endmodule

// File: design/atrp_front.sv
// Front end: accepts samples, squares the axes and forms the sums and numerators.
module atrp_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [atrp_pkg::DATA_W-1:0]     in_accel_x,
  input  logic signed [atrp_pkg::DATA_W-1:0]     in_accel_y,
  input  logic signed [atrp_pkg::DATA_W-1:0]     in_accel_z,
  output logic                                   item_vld,
  input  logic                                   item_rdy,
  output atrp_pkg::atrp_item_t                   item
);

  logic a_vld_r, b_vld_r, a_adv, b_adv;
  logic [atrp_pkg::SQR_W-1:0] xx_r, yy_r, zz_r;
  logic signed [atrp_pkg::NUM_W-1:0] nr_r, np_r;
  logic zero_r;
  logic signed [2*atrp_pkg::DATA_W-1:0] px, py, pz;
  atrp_pkg::atrp_item_t item_r, item_nxt;

  assign px = in_accel_x * in_accel_x;
  assign py = in_accel_y * in_accel_y;
  assign pz = in_accel_z * in_accel_z;

  assign b_adv    = !b_vld_r || item_rdy;
  assign a_adv    = !a_vld_r || b_adv;
  assign in_ready = a_adv;

  // stage A: squares and numerators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      xx_r   <= px[atrp_pkg::SQR_W-1:0];
      yy_r   <= py[atrp_pkg::SQR_W-1:0];
      zz_r   <= pz[atrp_pkg::SQR_W-1:0];
      nr_r   <= {in_accel_y[atrp_pkg::DATA_W-1], in_accel_y};
      np_r   <= -{in_accel_x[atrp_pkg::DATA_W-1], in_accel_x};
      zero_r <= (in_accel_x == '0) && (in_accel_y == '0) && (in_accel_z == '0);
    end
  end

  // stage B: sums of squares
  always_comb begin
    item_nxt.roll.sq   = {1'b0, zz_r} + {1'b0, xx_r};
    item_nxt.roll.num  = nr_r;
    item_nxt.pitch.sq  = {1'b0, zz_r} + {1'b0, yy_r};
    item_nxt.pitch.num = np_r;
    item_nxt.zero      = zero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      item_r <= item_nxt;
    end
  end

  assign item_vld = b_vld_r;
  assign item     = item_r;

endmodule

// File: design/atrp_fifo.sv
// Short queue between the front end and the arithmetic back end.
module atrp_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_vld,
  output logic                 push_rdy,
  input  atrp_pkg::atrp_item_t push_item,
  output logic                 pop_vld,
  input  logic                 pop,
  output atrp_pkg::atrp_item_t pop_item
);

  localparam int PTR_W = $clog2(atrp_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(atrp_pkg::FIFO_DEPTH + 1);

  atrp_pkg::atrp_item_t mem_r [atrp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic push, pull;

  assign push_rdy = (cnt_r != CNT_W'(atrp_pkg::FIFO_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign push     = push_vld && push_rdy;
  assign pull     = pop && pop_vld;
  assign pop_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(atrp_pkg::FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pull) begin
        rd_r <= (rd_r == PTR_W'(atrp_pkg::FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pull) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pull && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pull) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not rise on push");

  a_fill_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pull && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not fall on pop");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(atrp_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: design/atrp_sqrt.sv
// Pipelined floor square root, one root bit per stage, for both lanes.
module atrp_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  atrp_pkg::atrp_item_t     in_item,
  output logic                     out_vld,
  output atrp_pkg::atrp_hyp_item_t out_item
);

  localparam int N = atrp_pkg::SQRT_STEPS;

  function automatic atrp_pkg::atrp_sq_st_t sq_step(input atrp_pkg::atrp_sq_st_t s);
    logic [atrp_pkg::REM_W+1:0] acc;
    logic [atrp_pkg::REM_W+1:0] trial;
    atrp_pkg::atrp_sq_st_t o;
    o     = s;
    acc   = {s.rem, s.rad[atrp_pkg::SQ_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[atrp_pkg::SQ_W-3:0], 2'b00};
    if (acc >= trial) begin
      o.rem  = atrp_pkg::REM_W'(acc - trial);
      o.root = {s.root[atrp_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = acc[atrp_pkg::REM_W-1:0];
      o.root = {s.root[atrp_pkg::ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  atrp_pkg::atrp_sq_st_t st0 [2];
  atrp_pkg::atrp_sq_st_t st_r [1:N][2];
  logic zero_r [1:N];
  logic vld_r  [1:N];

  always_comb begin
    st0[0].rad  = in_item.roll.sq;
    st0[0].rem  = '0;
    st0[0].root = '0;
    st0[0].num  = in_item.roll.num;
    st0[1].rad  = in_item.pitch.sq;
    st0[1].rem  = '0;
    st0[1].root = '0;
    st0[1].num  = in_item.pitch.num;
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    atrp_pkg::atrp_sq_st_t src [2];
    logic src_vld, src_zero;
    if (k == 0) begin : g_head
      assign src[0]   = st0[0];
      assign src[1]   = st0[1];
      assign src_vld  = in_vld;
      assign src_zero = in_item.zero;
    end else begin : g_tail
      assign src[0]   = st_r[k][0];
      assign src[1]   = st_r[k][1];
      assign src_vld  = vld_r[k];
      assign src_zero = zero_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1][0] <= sq_step(src[0]);
        st_r[k+1][1] <= sq_step(src[1]);
        zero_r[k+1]  <= src_zero;
      end
    end
  end

  assign out_vld            = vld_r[N];
  assign out_item.roll.r    = st_r[N][0].root;
  assign out_item.roll.num  = st_r[N][0].num;
  assign out_item.pitch.r   = st_r[N][1].root;
  assign out_item.pitch.num = st_r[N][1].num;
  assign out_item.zero      = zero_r[N];

endmodule

// File: design/atrp_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per stage, for both lanes.
module atrp_cordic #(
  parameter int CORDIC_STEPS = atrp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_vld,
  input  atrp_pkg::atrp_hyp_item_t           in_item,
  output logic                               out_vld,
  output logic signed [atrp_pkg::Z_W-1:0]    out_z_roll,
  output logic signed [atrp_pkg::Z_W-1:0]    out_z_pitch,
  output logic                               out_zero
);

  localparam int N = CORDIC_STEPS;

  function automatic atrp_pkg::atrp_cv_t cv_step(input atrp_pkg::atrp_cv_t s,
                                                 input logic [atrp_pkg::IDX_W-1:0] i);
    logic signed [atrp_pkg::CV_W-1:0] dx, dy;
    atrp_pkg::atrp_cv_t o;
    dx = s.y >>> i;
    dy = s.x >>> i;
    if (!s.y[atrp_pkg::CV_W-1]) begin
      o.x = s.x + dx;
      o.y = s.y - dy;
      o.z = s.z + atrp_pkg::atan_q30(i);
    end else begin
      o.x = s.x - dx;
      o.y = s.y + dy;
      o.z = s.z - atrp_pkg::atan_q30(i);
    end
    return o;
  endfunction

  function automatic atrp_pkg::atrp_cv_t cv_init(input atrp_pkg::atrp_hyp_t h);
    atrp_pkg::atrp_cv_t o;
    o.x = atrp_pkg::CV_W'(h.r);
    o.y = {{(atrp_pkg::CV_W - atrp_pkg::NUM_W - 16){h.num[atrp_pkg::NUM_W-1]}},
           h.num, 16'b0};
    o.z = '0;
    return o;
  endfunction

  atrp_pkg::atrp_cv_t cv0 [2];
  atrp_pkg::atrp_cv_t cv_r [1:N][2];
  logic zero_r [1:N];
  logic vld_r  [1:N];

  assign cv0[0] = cv_init(in_item.roll);
  assign cv0[1] = cv_init(in_item.pitch);

  for (genvar i = 0; i < N; i++) begin : g_rot
    atrp_pkg::atrp_cv_t src [2];
    logic src_vld, src_zero;
    if (i == 0) begin : g_head
      assign src[0]   = cv0[0];
      assign src[1]   = cv0[1];
      assign src_vld  = in_vld;
      assign src_zero = in_item.zero;
    end else begin : g_tail
      assign src[0]   = cv_r[i][0];
      assign src[1]   = cv_r[i][1];
      assign src_vld  = vld_r[i];
      assign src_zero = zero_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cv_r[i+1][0] <= cv_step(src[0], atrp_pkg::IDX_W'(i));
        cv_r[i+1][1] <= cv_step(src[1], atrp_pkg::IDX_W'(i));
        zero_r[i+1]  <= src_zero;
      end
    end
  end

  assign out_vld     = vld_r[N];
  assign out_z_roll  = cv_r[N][0].z;
  assign out_z_pitch = cv_r[N][1].z;
  assign out_zero    = zero_r[N];

endmodule

// File: design/atrp_post.sv
// Output formatting: clamp, round to radians, scale to degrees, output register.
module atrp_post #(
  parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_vld,
  input  logic signed [atrp_pkg::Z_W-1:0]     in_z_roll,
  input  logic signed [atrp_pkg::Z_W-1:0]     in_z_pitch,
  input  logic                                in_zero,
  output logic                                out_vld,
  output logic signed [atrp_pkg::RAD_W-1:0]   roll_rad,
  output logic signed [atrp_pkg::RAD_W-1:0]   pitch_rad,
  output logic signed [atrp_pkg::DEG_W-1:0]   roll_deg,
  output logic signed [atrp_pkg::DEG_W-1:0]   pitch_deg
);

  localparam int SH = 30 - ANGLE_FRAC_BITS;

  function automatic logic [atrp_pkg::MAG_W-1:0] mag_of(input logic signed [atrp_pkg::Z_W-1:0] z,
                                                         input logic zero);
    logic signed [atrp_pkg::Z_W-1:0] c;
    if (zero) begin
      c = '0;
    end else if (z > atrp_pkg::HALF_PI_Q30) begin
      c = atrp_pkg::HALF_PI_Q30;
    end else if (z < -atrp_pkg::HALF_PI_Q30) begin
      c = -atrp_pkg::HALF_PI_Q30;
    end else begin
      c = z;
    end
    if (c[atrp_pkg::Z_W-1]) begin
      c = -c;
    end
    return c[atrp_pkg::MAG_W-1:0];
  endfunction

  function automatic logic [atrp_pkg::RAD_W-1:0] rad_of(input logic [atrp_pkg::MAG_W-1:0] m,
                                                         input logic neg);
    logic [atrp_pkg::RSUM_W-1:0] s;
    logic [atrp_pkg::RAD_W-1:0]  q;
    s = atrp_pkg::RSUM_W'(m) + (atrp_pkg::RSUM_W'(1) << (SH - 1));
    q = s[SH +: atrp_pkg::RAD_W];
    return neg ? -q : q;
  endfunction

  function automatic logic [atrp_pkg::DEG_W-1:0] deg_of(input logic [atrp_pkg::PROD_W-1:0] p,
                                                         input logic neg);
    logic [atrp_pkg::DMAG_W-1:0] d;
    logic [atrp_pkg::DEG_W-1:0]  e;
    d = p[atrp_pkg::DEG_SHIFT +: atrp_pkg::DMAG_W];
    if (d > atrp_pkg::DEG_MAX) begin
      d = atrp_pkg::DEG_MAX;
    end
    e = {1'b0, d};
    return neg ? -e : e;
  endfunction

  logic v1_r, v2_r, v3_r;
  logic [atrp_pkg::MAG_W-1:0]  mr_r, mp_r;
  logic                        nr1_r, np1_r, nr2_r, np2_r;
  logic [atrp_pkg::PROD_W-1:0] pr_r, pp_r;
  logic [atrp_pkg::RAD_W-1:0]  rr2_r, rp2_r, rr3_r, rp3_r;
  logic [atrp_pkg::DEG_W-1:0]  dr3_r, dp3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mr_r  <= mag_of(in_z_roll, in_zero);
      mp_r  <= mag_of(in_z_pitch, in_zero);
      nr1_r <= !in_zero && in_z_roll[atrp_pkg::Z_W-1];
      np1_r <= !in_zero && in_z_pitch[atrp_pkg::Z_W-1];
      pr_r  <= mr_r * atrp_pkg::RAD2DEG_Q24;
      pp_r  <= mp_r * atrp_pkg::RAD2DEG_Q24;
      rr2_r <= rad_of(mr_r, nr1_r);
      rp2_r <= rad_of(mp_r, np1_r);
      nr2_r <= nr1_r;
      np2_r <= np1_r;
      rr3_r <= rr2_r;
      rp3_r <= rp2_r;
      dr3_r <= deg_of(pr_r, nr2_r);
      dp3_r <= deg_of(pp_r, np2_r);
    end
  end

  assign out_vld   = v3_r;
  assign roll_rad  = rr3_r;
  assign pitch_rad = rp3_r;
  assign roll_deg  = dr3_r;
  assign pitch_deg = dp3_r;

endmodule

// File: sim/tb_accel_tilt_roll_pitch_unit.sv
// Testbench for the accelerometer tilt unit: predicts roll and pitch per sample and checks them.
`timescale 1ns / 1ps

module tb_accel_tilt_roll_pitch_unit;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_FROM   = 340;

  typedef struct {
    logic signed [atrp_pkg::RAD_W-1:0] roll_rad;
    logic signed [atrp_pkg::RAD_W-1:0] pitch_rad;
    logic signed [atrp_pkg::DEG_W-1:0] roll_deg;
    logic signed [atrp_pkg::DEG_W-1:0] pitch_deg;
  } tilt_angles_t;

  // Holds the angles predicted for accepted samples, oldest first, and
  // compares each result leaving the block with the oldest of them.
  class TiltScoreboard;
    tilt_angles_t expected_angles[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // Integer square root by the classic bit-pair method.
    static function longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Vectoring CORDIC: angle of (r, n) in Q30, clamped to +-pi/2.
    static function longint cordic_angle(longint unsigned r, longint n);
      longint cx, cy, cz, dx, dy;
      cx = longint'(r);
      cy = n * 65536;
      cz = 0;
      if (cx == 0 && cy == 0) return 0;
      for (int i = 0; i < atrp_pkg::CORDIC_STEPS_DEF && i < atrp_pkg::ATAN_LEN; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + longint'(atrp_pkg::atan_q30(i[atrp_pkg::IDX_W-1:0]));
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - longint'(atrp_pkg::atan_q30(i[atrp_pkg::IDX_W-1:0]));
        end
      end
      if (cz > longint'(atrp_pkg::HALF_PI_Q30)) cz = longint'(atrp_pkg::HALF_PI_Q30);
      if (cz < -longint'(atrp_pkg::HALF_PI_Q30)) cz = -longint'(atrp_pkg::HALF_PI_Q30);
      return cz;
    endfunction

    static function logic [atrp_pkg::RAD_W-1:0] q30_to_rad(longint cz);
      longint unsigned mag, q;
      int sh;
      sh  = 30 - atrp_pkg::ANGLE_FRAC_BITS_DEF;
      mag = (cz < 0) ? longint'(-cz) : longint'(cz);
      q   = (mag + (64'd1 << (sh - 1))) >> sh;
      return (cz < 0) ? (atrp_pkg::RAD_W)'(-q) : (atrp_pkg::RAD_W)'(q);
    endfunction

    static function logic [atrp_pkg::DEG_W-1:0] q30_to_deg(longint cz);
      longint unsigned mag, d;
      mag = (cz < 0) ? longint'(-cz) : longint'(cz);
      d   = (mag * longint'(atrp_pkg::RAD2DEG_Q24)) >> atrp_pkg::DEG_SHIFT;
      if (d > 90) d = 90;
      return (cz < 0) ? (atrp_pkg::DEG_W)'(-d) : (atrp_pkg::DEG_W)'(d);
    endfunction

    static function tilt_angles_t predict_tilt(logic signed [atrp_pkg::DATA_W-1:0] ax,
                                               logic signed [atrp_pkg::DATA_W-1:0] ay,
                                               logic signed [atrp_pkg::DATA_W-1:0] az);
      tilt_angles_t    t;
      longint          x, y, z, roll, pitch;
      longint unsigned hr, hp;
      x = ax;
      y = ay;
      z = az;
      hr    = floor_root(longint'(z * z + x * x) << 32);
      hp    = floor_root(longint'(z * z + y * y) << 32);
      roll  = cordic_angle(hr, y);
      // -X is formed at full width, so the most negative X is safe
      pitch = cordic_angle(hp, -x);
      t.roll_rad  = q30_to_rad(roll);
      t.pitch_rad = q30_to_rad(pitch);
      t.roll_deg  = q30_to_deg(roll);
      t.pitch_deg = q30_to_deg(pitch);
      return t;
    endfunction

    function void note_sample(logic signed [atrp_pkg::DATA_W-1:0] ax,
                              logic signed [atrp_pkg::DATA_W-1:0] ay,
                              logic signed [atrp_pkg::DATA_W-1:0] az);
      expected_angles.push_back(predict_tilt(ax, ay, az));
    endfunction

    function void check_result(tilt_angles_t got);
      tilt_angles_t e;
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result roll_rad=%0d pitch_rad=%0d", $time,
                 got.roll_rad, got.pitch_rad);
        errors++;
        return;
      end
      e = expected_angles.pop_front();
      if (got.roll_rad !== e.roll_rad) begin
        $display("%0t: roll_rad expected %0d actual %0d", $time, e.roll_rad, got.roll_rad);
        errors++;
      end
      if (got.pitch_rad !== e.pitch_rad) begin
        $display("%0t: pitch_rad expected %0d actual %0d", $time, e.pitch_rad, got.pitch_rad);
        errors++;
      end
      if (got.roll_deg !== e.roll_deg) begin
        $display("%0t: roll_deg expected %0d actual %0d", $time, e.roll_deg, got.roll_deg);
        errors++;
      end
      if (got.pitch_deg !== e.pitch_deg) begin
        $display("%0t: pitch_deg expected %0d actual %0d", $time, e.pitch_deg,
                 got.pitch_deg);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [atrp_pkg::DATA_W-1:0] in_accel_x;
  logic signed [atrp_pkg::DATA_W-1:0] in_accel_y;
  logic signed [atrp_pkg::DATA_W-1:0] in_accel_z;
  logic out_valid;
  logic out_ready;
  logic signed [atrp_pkg::RAD_W-1:0] out_roll_rad;
  logic signed [atrp_pkg::RAD_W-1:0] out_pitch_rad;
  logic signed [atrp_pkg::DEG_W-1:0] out_roll_deg;
  logic signed [atrp_pkg::DEG_W-1:0] out_pitch_deg;

  TiltScoreboard tilt_sb;
  bit            quiet;     // set for the last stretch: no idling on either side
  int            cycle_count;

  accel_tilt_roll_pitch_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_roll_rad  (out_roll_rad),
    .out_pitch_rad (out_pitch_rad),
    .out_roll_deg  (out_roll_deg),
    .out_pitch_deg (out_pitch_deg)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: abandon the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check every result taken at an edge; sampled values are the pre-edge ones.
  always @(posedge clk) begin
    tilt_angles_t got;
    if (rst_n && out_valid && out_ready) begin
      got.roll_rad  = out_roll_rad;
      got.pitch_rad = out_pitch_rad;
      got.roll_deg  = out_roll_deg;
      got.pitch_deg = out_pitch_deg;
      tilt_sb.check_result(got);
    end
  end

  // Receiver: alternate ready stretches with stall bursts, both of random length.
  initial begin
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Present one sample and hold it until the block takes it.
  task automatic send_sample(logic signed [atrp_pkg::DATA_W-1:0] ax,
                             logic signed [atrp_pkg::DATA_W-1:0] ay,
                             logic signed [atrp_pkg::DATA_W-1:0] az);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    do @(posedge clk); while (!in_ready);
    tilt_sb.note_sample(ax, ay, az);
  endtask

  // Pick an axis value: full range mostly, with extremes and small tilts mixed in.
  function automatic logic signed [atrp_pkg::DATA_W-1:0] pick_axis();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3, 4:    return atrp_pkg::DATA_W'($signed($urandom_range(0, 400)) - 200);
      default: return atrp_pkg::DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    tilt_sb     = new();
    quiet       = 1'b0;
    cycle_count = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_accel_x  = '0;
    in_accel_y  = '0;
    in_accel_z  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero sample, lone axes, zero hypotenuse, field extremes
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd16384);
    send_sample(16'sd0, 16'sd0, -16'sd16384);
    send_sample(16'sd0, 16'sd1, 16'sd0);
    send_sample(16'sd0, -16'sd1, 16'sd0);
    send_sample(16'sd1, 16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    send_sample(16'sh7FFF, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sh8000, 16'sd0);
    send_sample(16'sd0, 16'sh7FFF, 16'sd0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    send_sample(16'sd1, 16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sd1000, -16'sd1000, 16'sd0);
    send_sample(16'sd0, 16'sd5, 16'sd8192);

    // Random samples; the last stretch runs with no idling at all
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == QUIET_FROM) quiet = 1'b1;
      send_sample(pick_axis(), pick_axis(), pick_axis());
    end
    in_valid <= 1'b0;

    while (tilt_sb.expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tilt_sb.errors == 0 && tilt_sb.expected_angles.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/atrp_pkg.sv
design/atrp_front.sv
design/atrp_fifo.sv
design/atrp_sqrt.sv
design/atrp_cordic.sv
design/atrp_post.sv
design/accel_tilt_roll_pitch_unit.sv
sim/tb_accel_tilt_roll_pitch_unit.sv
